### rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### rtl/idte_pkg.sv
// Package: request and result types, codes and FSM states of the node table engine.
`default_nettype none
package idte_pkg;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [2:0] {
    ACT_CREATE = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_ADD    = 3'd3,
    ACT_RESET  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_FILE = 2'd1,
    KIND_DIR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KIND,
    ST_CHILD,
    ST_CSCAN,
    ST_ASCAN,
    ST_RSCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    action_t     action;
    logic        node_kind_in;
    logic [5:0]  slot_index;
    logic [5:0]  child_index;
    logic [63:0] entry_name;
  } req_t;

  typedef struct packed {
    logic       status;
    logic [5:0] slot_number;
    logic [1:0] node_kind_out;
  } res_t;

endpackage
`default_nettype wire

### rtl/idte_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module idte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/idte_ctrl.sv
// Sequencer: checks operands, scans the kind, entry-used and child memories, writes back.
`default_nettype none
`include "assert_macros.svh"
module idte_ctrl #(
  parameter int SLOT_COUNT      = 64,
  parameter int ENTRIES_PER_DIR = 16,
  parameter int SLOT_W          = $clog2(SLOT_COUNT),
  parameter int EW              = (ENTRIES_PER_DIR > 1) ? $clog2(ENTRIES_PER_DIR) : 1,
  parameter int EAW             = $clog2(SLOT_COUNT * ENTRIES_PER_DIR)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire idte_pkg::req_t             in_req,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output idte_pkg::res_t                  res,
  // slot kind memory
  output logic                            kind_we,
  output logic [SLOT_W-1:0]               kind_waddr,
  output logic [1:0]                      kind_wd,
  output logic [SLOT_W-1:0]               kind_raddr,
  input  wire logic [1:0]                 kind_rd,
  // entry-used rows, one row per slot
  output logic                            used_we,
  output logic [SLOT_W-1:0]               used_waddr,
  output logic [ENTRIES_PER_DIR-1:0]      used_wd,
  output logic [SLOT_W-1:0]               used_raddr,
  input  wire logic [ENTRIES_PER_DIR-1:0] used_rd,
  // entry child numbers
  output logic                            child_we,
  output logic [EAW-1:0]                  ent_addr,
  output logic [5:0]                      child_wd,
  input  wire logic [5:0]                 child_rd
);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [EW-1:0]     ENT_LAST  = EW'(ENTRIES_PER_DIR - 1);

  idte_pkg::state_t state, state_next;
  idte_pkg::req_t   req_r, req_next;
  idte_pkg::res_t   res_r, res_next;
  logic [SLOT_W-1:0] sscan, sscan_next;
  logic [SLOT_W-1:0] schk, schk_next;
  logic [EW-1:0]     escan, escan_next;
  logic [EW-1:0]     echk, echk_next;
  logic              ckv, ckv_next;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] child_r;

  function automatic logic in_range(input logic [5:0] v);
    return 32'(v) < SLOT_COUNT;
  endfunction

  assign slot_r  = SLOT_W'(req_r.slot_index);
  assign child_r = SLOT_W'(req_r.child_index);
  assign res     = res_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idte_pkg::ST_CLEAR;
      sscan <= '0;
      ckv   <= 1'b0;
    end else begin
      state <= state_next;
      sscan <= sscan_next;
      ckv   <= ckv_next;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_next;
    res_r <= res_next;
    schk  <= schk_next;
    escan <= escan_next;
    echk  <= echk_next;
  end

  always_comb begin
    state_next = state;
    req_next   = req_r;
    res_next   = res_r;
    sscan_next = sscan;
    schk_next  = schk;
    escan_next = escan;
    echk_next  = echk;
    ckv_next   = ckv;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    kind_we    = 1'b0;
    kind_waddr = slot_r;
    kind_wd    = idte_pkg::KIND_FREE;
    kind_raddr = slot_r;
    used_we    = 1'b0;
    used_waddr = slot_r;
    used_wd    = used_rd;
    used_raddr = slot_r;
    child_we   = 1'b0;
    child_wd   = req_r.child_index;
    ent_addr   = EAW'(slot_r) * EAW'(ENTRIES_PER_DIR) + EAW'(escan);

    case (state)
      idte_pkg::ST_CLEAR: begin
        // walk the kind memory once after reset, marking every slot free
        kind_we    = 1'b1;
        kind_waddr = sscan;
        if (sscan == SLOT_LAST) begin
          sscan_next = '0;
          state_next = idte_pkg::ST_IDLE;
        end else begin
          sscan_next = sscan + 1'b1;
        end
      end

      idte_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        kind_raddr = SLOT_W'(in_req.slot_index);
        used_raddr = SLOT_W'(in_req.slot_index);
        if (in_valid) begin
          req_next               = in_req;
          res_next.status        = 1'b1;
          res_next.slot_number   = in_req.slot_index;
          res_next.node_kind_out = idte_pkg::KIND_FREE;
          sscan_next             = '0;
          ckv_next               = 1'b0;
          case (in_req.action)
            idte_pkg::ACT_CREATE: begin
              res_next.slot_number = '0;
              state_next           = idte_pkg::ST_CSCAN;
            end
            idte_pkg::ACT_DELETE, idte_pkg::ACT_GET,
            idte_pkg::ACT_ADD, idte_pkg::ACT_RESET: begin
              state_next = in_range(in_req.slot_index) ? idte_pkg::ST_KIND
                                                       : idte_pkg::ST_DONE;
            end
            default: state_next = idte_pkg::ST_DONE;
          endcase
        end
      end

      idte_pkg::ST_KIND: begin
        state_next = idte_pkg::ST_DONE;
        case (req_r.action)
          idte_pkg::ACT_DELETE: begin
            if (kind_rd != idte_pkg::KIND_FREE) begin
              kind_we         = 1'b1;
              res_next.status = 1'b0;
            end
          end
          idte_pkg::ACT_GET: begin
            if (kind_rd != idte_pkg::KIND_FREE) begin
              res_next.status        = 1'b0;
              res_next.node_kind_out = kind_rd;
            end
          end
          idte_pkg::ACT_ADD, idte_pkg::ACT_RESET: begin
            if (kind_rd == idte_pkg::KIND_DIR && in_range(req_r.child_index) &&
                (req_r.action == idte_pkg::ACT_RESET || req_r.entry_name[7:0] != 8'd0)) begin
              kind_raddr = child_r;
              state_next = idte_pkg::ST_CHILD;
            end
          end
          default: state_next = idte_pkg::ST_DONE;
        endcase
      end

      idte_pkg::ST_CHILD: begin
        escan_next = '0;
        ckv_next   = 1'b0;
        if (kind_rd == idte_pkg::KIND_FREE) begin
          state_next = idte_pkg::ST_DONE;
        end else if (req_r.action == idte_pkg::ACT_ADD) begin
          state_next = idte_pkg::ST_ASCAN;
        end else begin
          state_next = idte_pkg::ST_RSCAN;
        end
      end

      idte_pkg::ST_CSCAN: begin
        // read runs one slot ahead of the check
        kind_raddr = sscan;
        if (ckv && kind_rd == idte_pkg::KIND_FREE) begin
          kind_we    = 1'b1;
          kind_waddr = schk;
          kind_wd    = req_r.node_kind_in ? idte_pkg::KIND_DIR : idte_pkg::KIND_FILE;
          used_we    = req_r.node_kind_in;
          used_waddr = schk;
          used_wd    = '0;
          res_next.status      = 1'b0;
          res_next.slot_number = 6'(schk);
          state_next = idte_pkg::ST_DONE;
        end else if (ckv && schk == SLOT_LAST) begin
          state_next = idte_pkg::ST_DONE;
        end else begin
          schk_next = sscan;
          ckv_next  = 1'b1;
          if (sscan != SLOT_LAST) begin
            sscan_next = sscan + 1'b1;
          end
        end
      end

      idte_pkg::ST_ASCAN: begin
        if (!used_rd[escan]) begin
          used_we         = 1'b1;
          used_wd         = used_rd | (ENTRIES_PER_DIR'(1) << escan);
          child_we        = 1'b1;
          res_next.status = 1'b0;
          state_next      = idte_pkg::ST_DONE;
        end else if (escan == ENT_LAST) begin
          state_next = idte_pkg::ST_DONE;
        end else begin
          escan_next = escan + 1'b1;
        end
      end

      idte_pkg::ST_RSCAN: begin
        if (ckv && used_rd[echk] && child_rd == req_r.child_index) begin
          used_we         = 1'b1;
          used_wd         = used_rd & ~(ENTRIES_PER_DIR'(1) << echk);
          res_next.status = 1'b0;
          state_next      = idte_pkg::ST_DONE;
        end else if (ckv && echk == ENT_LAST) begin
          state_next = idte_pkg::ST_DONE;
        end else begin
          echk_next = escan;
          ckv_next  = 1'b1;
          if (escan != ENT_LAST) begin
            escan_next = escan + 1'b1;
          end
        end
      end

      idte_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = idte_pkg::ST_IDLE;
        end
      end

      default: state_next = idte_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_IMPLIES(a_create_takes_free, clk, rst,
    state == idte_pkg::ST_CSCAN && kind_we, kind_rd == idte_pkg::KIND_FREE)
  `ASSERT_IMPLIES(a_add_takes_unused, clk, rst,
    state == idte_pkg::ST_ASCAN && used_we, !used_rd[escan])
  `ASSERT_NEXT(a_result_holds, clk, rst,
    state == idte_pkg::ST_DONE && !res_ready, state == idte_pkg::ST_DONE && $stable(res_r))

endmodule
`default_nettype wire

### rtl/inode_directory_table_engine_core.sv
// Top level: stream ports, memories, sequencer and output register of the node table engine.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | request: tuser action, tdata kind/slot/child/name
//  m_*     | out | m_tvalid/m_tready  | result: tdata status/slot_number/node_kind_out
//
// One request at a time. Create walks the kind memory one slot per cycle. Add entry walks
// the used row held at the entry-used memory output; reset entry walks the child memory
// one entry per cycle. After reset a clearing pass marks all slots free; s_tready stays
// low meanwhile. The output register lets a request be taken while the last result
// waits on m_tready.
`default_nettype none
`include "assert_macros.svh"
module inode_directory_table_engine_core #(
  parameter int SLOT_COUNT      = 64,
  parameter int ENTRIES_PER_DIR = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [0] node_kind_in, [6:1] slot_index, [12:7] child_index, [76:13] entry_name
  input  wire logic [idte_pkg::IN_DATA_W-1:0]    s_tdata,
  // [2:0] action
  input  wire logic [2:0]                        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [0] status, [6:1] slot_number, [8:7] node_kind_out
  output logic      [idte_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int EW     = (ENTRIES_PER_DIR > 1) ? $clog2(ENTRIES_PER_DIR) : 1;
  localparam int EAW    = $clog2(SLOT_COUNT * ENTRIES_PER_DIR);

  idte_pkg::req_t in_req;
  idte_pkg::res_t res;
  logic res_valid, res_ready;

  logic                       kind_we;
  logic [SLOT_W-1:0]          kind_waddr, kind_raddr;
  logic [1:0]                 kind_wd, kind_rd;
  logic                       used_we;
  logic [SLOT_W-1:0]          used_waddr, used_raddr;
  logic [ENTRIES_PER_DIR-1:0] used_wd, used_rd;
  logic                       child_we;
  logic [EAW-1:0]             ent_addr;
  logic [5:0]                 child_wd, child_rd;

  // names are checked for an empty first byte but not kept: nothing reads them back
  assign in_req.action       = idte_pkg::action_t'(s_tuser);
  assign in_req.node_kind_in = s_tdata[0];
  assign in_req.slot_index   = s_tdata[6:1];
  assign in_req.child_index  = s_tdata[12:7];
  assign in_req.entry_name   = s_tdata[76:13];

  assign res_ready = !m_tvalid || m_tready;

  idte_ctrl #(
    .SLOT_COUNT      (SLOT_COUNT),
    .ENTRIES_PER_DIR (ENTRIES_PER_DIR),
    .SLOT_W          (SLOT_W),
    .EW              (EW),
    .EAW             (EAW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req     (in_req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .kind_we    (kind_we),
    .kind_waddr (kind_waddr),
    .kind_wd    (kind_wd),
    .kind_raddr (kind_raddr),
    .kind_rd    (kind_rd),
    .used_we    (used_we),
    .used_waddr (used_waddr),
    .used_wd    (used_wd),
    .used_raddr (used_raddr),
    .used_rd    (used_rd),
    .child_we   (child_we),
    .ent_addr   (ent_addr),
    .child_wd   (child_wd),
    .child_rd   (child_rd)
  );

  idte_ram #(.WIDTH(2), .DEPTH(SLOT_COUNT), .AW(SLOT_W)) u_kind_ram (
    .clk     (clk),
    .wr_en   (kind_we),
    .wr_addr (kind_waddr),
    .wr_data (kind_wd),
    .rd_addr (kind_raddr),
    .rd_data (kind_rd)
  );

  idte_ram #(.WIDTH(ENTRIES_PER_DIR), .DEPTH(SLOT_COUNT), .AW(SLOT_W)) u_used_ram (
    .clk     (clk),
    .wr_en   (used_we),
    .wr_addr (used_waddr),
    .wr_data (used_wd),
    .rd_addr (used_raddr),
    .rd_data (used_rd)
  );

  idte_ram #(.WIDTH(6), .DEPTH(SLOT_COUNT * ENTRIES_PER_DIR), .AW(EAW)) u_child_ram (
    .clk     (clk),
    .wr_en   (child_we),
    .wr_addr (ent_addr),
    .wr_data (child_wd),
    .rd_addr (ent_addr),
    .rd_data (child_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {7'd0, res.node_kind_out, res.slot_number, res.status};
    end
  end

  // a result is handed over once, then the sequencer returns to idle
  `ASSERT_NEXT(a_result_once, clk, rst, res_valid && res_ready, !res_valid)

endmodule
`default_nettype wire

### tb/idte_result_checker.sv
// Checker for the node table engine: watches both streams, predicts every result, compares.
module idte_result_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  // [0] node_kind_in, [6:1] slot_index, [12:7] child_index, [76:13] entry_name
  input  wire logic [idte_pkg::IN_DATA_W-1:0] s_tdata,
  // [2:0] action
  input  wire logic [2:0]                     s_tuser,
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  // [0] status, [6:1] slot_number, [8:7] node_kind_out
  input  wire logic [idte_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                                  errors,
  output int                                  pending,
  output int                                  checked
);
  import idte_pkg::*;

  localparam int SLOTS   = 64;
  localparam int ENTRIES = 16;

  kind_t      slot_kind_m [SLOTS];
  logic       used_m      [SLOTS*ENTRIES];
  logic [5:0] child_m     [SLOTS*ENTRIES];
  res_t       answers_due [$];
  int         err_n;
  int         seen_n;

  function automatic logic slot_taken(input logic [5:0] s);
    return (int'(s) < SLOTS) && (slot_kind_m[s] != KIND_FREE);
  endfunction

  // Applies one request to the shadow table and returns the result it should produce.
  function automatic res_t predict_answer(input logic [2:0] act, input logic kin,
                                          input logic [5:0] slot, input logic [5:0] child,
                                          input logic [63:0] name);
    res_t r;
    int   base;
    logic hit;
    r.status        = 1'b1;
    r.slot_number   = slot;
    r.node_kind_out = KIND_FREE;
    base            = int'(slot) * ENTRIES;
    hit             = 1'b0;
    case (act)
      ACT_CREATE: begin
        r.slot_number = '0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!hit && slot_kind_m[i] == KIND_FREE) begin
            hit            = 1'b1;
            slot_kind_m[i] = kin ? KIND_DIR : KIND_FILE;
            // only a new directory wipes its entry row
            if (kin)
              for (int j = 0; j < ENTRIES; j++) used_m[i*ENTRIES + j] = 1'b0;
            r.slot_number  = i[5:0];
            r.status       = 1'b0;
          end
        end
      end
      ACT_DELETE: begin
        if (slot_taken(slot)) begin
          slot_kind_m[slot] = KIND_FREE;
          r.status          = 1'b0;
        end
      end
      ACT_GET: begin
        if (slot_taken(slot)) begin
          r.node_kind_out = slot_kind_m[slot];
          r.status        = 1'b0;
        end
      end
      ACT_ADD: begin
        if (slot_taken(slot) && slot_kind_m[slot] == KIND_DIR && slot_taken(child) &&
            name[7:0] != 8'h00) begin
          for (int j = 0; j < ENTRIES; j++) begin
            if (!hit && !used_m[base + j]) begin
              hit               = 1'b1;
              used_m[base + j]  = 1'b1;
              child_m[base + j] = child;
              r.status          = 1'b0;
            end
          end
        end
      end
      ACT_RESET: begin
        if (slot_taken(slot) && slot_kind_m[slot] == KIND_DIR && slot_taken(child)) begin
          for (int j = 0; j < ENTRIES; j++) begin
            if (!hit && used_m[base + j] && child_m[base + j] == child) begin
              hit              = 1'b1;
              used_m[base + j] = 1'b0;
              r.status         = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_kind_m[i] = KIND_FREE;
      for (int i = 0; i < SLOTS*ENTRIES; i++) used_m[i] = 1'b0;
      answers_due.delete();
      err_n   = 0;
      seen_n  = 0;
      errors  <= 0;
      pending <= 0;
      checked <= 0;
    end else begin
      // a result never belongs to a request taken at the same edge, so order is free
      if (m_tvalid && m_tready) begin
        seen_n++;
        if (answers_due.size() == 0) begin
          if (err_n < 10)
            $display("unexpected result %h with no request outstanding", m_tdata);
          err_n++;
        end else begin
          want = answers_due.pop_front();
          if (m_tdata[0] !== want.status || m_tdata[6:1] !== want.slot_number ||
              m_tdata[8:7] !== want.node_kind_out) begin
            if (err_n < 10)
              $display("result %0d mismatch: expected status %0d slot %0d kind %0d, got %b %b %b",
                       seen_n, want.status, want.slot_number, want.node_kind_out,
                       m_tdata[0], m_tdata[6:1], m_tdata[8:7]);
            err_n++;
          end
        end
      end
      if (s_tvalid && s_tready)
        answers_due.push_back(predict_answer(s_tuser, s_tdata[0], s_tdata[6:1],
                                             s_tdata[12:7], s_tdata[76:13]));
      errors  <= err_n;
      checked <= seen_n;
      pending <= answers_due.size();
    end
  end

endmodule

### tb/tb_top.sv
// Testbench top: clock, reset, request stimulus and result sink around the node table engine.
module tb_top;
  import idte_pkg::*;

  localparam int           CYCLE_LIMIT = 400000;
  localparam int           RANDOM_UNTIL = 530;
  localparam logic [2:0]   ACT_SPARE5 = 3'd5;
  localparam logic [2:0]   ACT_SPARE6 = 3'd6;
  localparam logic [2:0]   ACT_SPARE7 = 3'd7;
  localparam logic         KIN_FILE = 1'b0;
  localparam logic         KIN_DIR  = 1'b1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [2:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int   errors;
  int   pending;
  int   checked;
  int   sent = 0;
  int   cycles = 0;
  int   rx_wait = 0;
  logic steady_tx = 1'b0;
  logic steady_rx = 1'b0;
  int   fills = 0;
  int   dir_fills = 0;
  int   drains = 0;

  always #4 clk = ~clk;

  inode_directory_table_engine_core #(
    .SLOT_COUNT      (64),
    .ENTRIES_PER_DIR (16)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  idte_result_checker chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  // Result sink: after each accepted result, tready may drop for a wait drawn at random, unless steady_rx is set.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else if (m_tready) begin
      if (m_tvalid) begin : draw
        int w;
        w = steady_rx ? 0 : $urandom_range(0, 6);
        if (w != 0) begin
          m_tready <= 1'b0;
          rx_wait  <= w - 1;
        end
      end
    end else if (rx_wait == 0) begin
      m_tready <= 1'b1;
    end else begin
      rx_wait <= rx_wait - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] random_label(input bit empty);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (empty)
      v[7:0] = 8'h00;
    else if (v[7:0] == 8'h00)
      v[7:0] = 8'h5a;
    // a zero byte further in does not matter: only the first byte is checked
    if (!empty && $urandom_range(0, 3) == 0)
      v[8*$urandom_range(1, 7) +: 8] = 8'h00;
    return v;
  endfunction

  function automatic logic [5:0] pick_slot();
    return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 15));
  endfunction

  function automatic logic [5:0] pick_child();
    return ($urandom_range(0, 9) < 3) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
  endfunction

  // Offers one request; tvalid is only dropped when a gap precedes the next one.
  task automatic issue(input logic [2:0] act, input logic kin, input logic [5:0] slot,
                       input logic [5:0] child, input logic [63:0] name);
    int gap;
    gap = steady_tx ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {3'b000, name, child, slot, kin};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // Holds off until every outstanding result has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int         pick;
    int         p;
    logic [5:0] dir;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, first creates, failures of get, delete, add and reset, stale entries
    issue(ACT_GET,    KIN_FILE, 6'd0,  6'd0,  64'h61);
    issue(ACT_DELETE, KIN_FILE, 6'd5,  6'd0,  64'h61);
    issue(ACT_ADD,    KIN_FILE, 6'd0,  6'd0,  64'h61);
    issue(ACT_CREATE, KIN_FILE, 6'd63, 6'd63, '1);
    issue(ACT_CREATE, KIN_DIR,  6'd0,  6'd0,  '0);
    issue(ACT_CREATE, KIN_DIR,  6'd0,  6'd0,  '0);
    issue(ACT_GET,    KIN_FILE, 6'd0,  6'd0,  '0);
    issue(ACT_GET,    KIN_FILE, 6'd1,  6'd0,  '0);
    issue(ACT_ADD,    KIN_FILE, 6'd1,  6'd0,  64'h0000_0000_0063_6261);
    issue(ACT_ADD,    KIN_DIR,  6'd1,  6'd2,  64'hFFFF_FFFF_FFFF_FFFF);
    issue(ACT_ADD,    KIN_FILE, 6'd1,  6'd1,  64'hFFFF_FF00_FFFF_FFFF);
    issue(ACT_ADD,    KIN_FILE, 6'd1,  6'd0,  64'hFFFF_FFFF_FFFF_FF00);
    issue(ACT_ADD,    KIN_FILE, 6'd0,  6'd1,  64'h41);
    issue(ACT_ADD,    KIN_FILE, 6'd1,  6'd63, 64'h41);
    issue(ACT_RESET,  KIN_FILE, 6'd1,  6'd0,  '0);
    issue(ACT_RESET,  KIN_FILE, 6'd1,  6'd0,  '0);
    issue(ACT_RESET,  KIN_FILE, 6'd1,  6'd63, '0);
    issue(ACT_RESET,  KIN_FILE, 6'd0,  6'd1,  '0);
    issue(ACT_SPARE5, KIN_DIR,  6'd63, 6'd63, '1);
    issue(ACT_SPARE6, KIN_FILE, 6'd1,  6'd2,  64'h42);
    issue(ACT_SPARE7, KIN_DIR,  6'd42, 6'd21, 64'h5555_AAAA_5555_AAAA);
    issue(ACT_DELETE, KIN_FILE, 6'd0,  6'd0,  '0);
    issue(ACT_GET,    KIN_FILE, 6'd0,  6'd0,  '0);
    // child 2 deleted: its entry stays, but reset fails while slot 2 is free
    issue(ACT_DELETE, KIN_FILE, 6'd2,  6'd0,  '0);
    issue(ACT_RESET,  KIN_FILE, 6'd1,  6'd2,  '0);
    issue(ACT_CREATE, KIN_FILE, 6'd0,  6'd0,  '0);
    issue(ACT_CREATE, KIN_DIR,  6'd0,  6'd0,  '0);
    issue(ACT_RESET,  KIN_FILE, 6'd1,  6'd2,  '0);
    settle();

    while (sent < RANDOM_UNTIL) begin
      pick      = $urandom_range(0, 9);
      steady_tx = ($urandom_range(0, 3) == 0);
      steady_rx <= ($urandom_range(0, 3) == 0);
      case (pick)
        0, 1: begin
          // overfill so create hits a full table
          fills++;
          repeat (66) issue(ACT_CREATE, 1'($urandom_range(0, 1)), pick_slot(), pick_child(),
                            random_label(0));
        end
        2: begin
          dir_fills++;
          dir = 6'($urandom_range(0, 15));
          repeat (18) issue(ACT_ADD, 1'($urandom_range(0, 1)), dir, pick_child(),
                            random_label($urandom_range(0, 15) == 0));
          repeat (6) issue(ACT_RESET, 1'($urandom_range(0, 1)), dir, pick_child(),
                           random_label(0));
        end
        3: begin
          drains++;
          repeat (24) issue(ACT_DELETE, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                            pick_child(), random_label(0));
          if ($urandom_range(0, 1) == 0)
            settle();
        end
        9: begin
          repeat (10) issue(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                            6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                            {$urandom, $urandom});
        end
        default: begin
          repeat (20) begin
            p = $urandom_range(0, 99);
            if (p < 15)
              issue(ACT_CREATE, 1'($urandom_range(0, 1)), pick_slot(), pick_child(),
                    random_label(0));
            else if (p < 25)
              issue(ACT_DELETE, 1'($urandom_range(0, 1)), pick_slot(), pick_child(),
                    random_label(0));
            else if (p < 40)
              issue(ACT_GET, 1'($urandom_range(0, 1)), pick_slot(), pick_child(),
                    random_label(0));
            else if (p < 70)
              issue(ACT_ADD, 1'($urandom_range(0, 1)), pick_slot(), pick_child(),
                    random_label($urandom_range(0, 9) == 0));
            else if (p < 90)
              issue(ACT_RESET, 1'($urandom_range(0, 1)), pick_slot(), pick_child(),
                    random_label(0));
            else
              issue(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), {$urandom, $urandom});
          end
        end
      endcase
    end

    settle();
    repeat (100) @(posedge clk);

    $display("%0d requests sent, %0d results checked", sent, checked);
    $display("bursts: %0d table fills, %0d directory fills, %0d delete sweeps",
             fills, dir_fills, drains);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
